/* sv/cemi_pkg.sv */
`timescale 1ns / 1ps

package cemi_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // input word kinds (tuser)
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ACCEL     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEED     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ROT_ACCEL = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ROT_SPEED = 2'd3;

    // shared iterative unit operations
    localparam logic OP_SQRT = 1'b0;
    localparam logic OP_DIV  = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_sts_t;

endpackage

/* sv/cemi_iter.sv */
`timescale 1ns / 1ps

// Shared radix-2 unit: floor square root of a 2W-bit value, or a 2W-bit
// by W-bit division whose quotient is known to fit in W bits.
// One result bit per cycle.
module cemi_iter #(
    parameter int WORD_BITS = cemi_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cemi_pkg::iter_ctl_t      ctl,
    input  logic [2*WORD_BITS-1:0]   a,
    input  logic [WORD_BITS-1:0]     d,
    output cemi_pkg::iter_sts_t      sts,
    output logic [WORD_BITS-1:0]     result
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic            op_reg;
    logic [CW-1:0]   cnt_reg;
    logic [W+1:0]    rem_reg, rem_next;
    logic [2*W-1:0]  src_reg, src_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [W-1:0]    d_reg;

    logic [W+1:0]    sq_r2;
    logic [W+1:0]    sq_trial;
    logic [W:0]      dv_r2;
    logic            ge;

    always_comb
    begin
        sq_r2    = {rem_reg[W-1:0], src_reg[2*W-1:2*W-2]};
        sq_trial = {quo_reg, 2'b01};
        dv_r2    = {rem_reg[W-1:0], src_reg[2*W-1]};
        if (op_reg == cemi_pkg::OP_SQRT)
        begin
            ge       = (sq_r2 >= sq_trial);
            rem_next = ge ? (sq_r2 - sq_trial) : sq_r2;
            src_next = src_reg << 2;
        end
        else
        begin
            ge       = (dv_r2 >= {1'b0, d_reg});
            rem_next = {1'b0, (ge ? (dv_r2 - {1'b0, d_reg}) : dv_r2)};
            src_next = src_reg << 1;
        end
        quo_next = {quo_reg[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= cemi_pkg::OP_SQRT;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            d_reg   <= d;
            quo_reg <= '0;
            if (ctl.op == cemi_pkg::OP_SQRT)
            begin
                rem_reg <= '0;
                src_reg <= a;
            end
            else
            begin
                rem_reg <= {2'b00, a[2*W-1:W]};
                src_reg <= {a[W-1:0], {W{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            src_reg <= src_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = quo_reg;

endmodule

/* sv/clamped_euler_motion_integrator.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: 8 deltas, time_step
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: move_x, move_y, move_z, turn_amount
// cfg      in   cfg_we (no wait)              cfg_index, cfg_data
//
// A kind-0 word is taken without holding the input, and so is a kind-1 word with
// a zero step. A kind-1 word with a nonzero step holds the input until its result
// moves to the output register, and each vector that is capped adds one square
// root and three divisions on the shared square-root/divide unit. Reset clears
// all motion state and sets every limit to its largest value. A finished result
// waits in the output register; the next word is taken meanwhile, and a later
// result stalls only until that register empties.
module clamped_euler_motion_integrator #(
    parameter int WORD_BITS = cemi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cemi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // kind
    input  logic                                   s_axis_tuser,
    // delta_vel_x, delta_vel_y, delta_vel_z, delta_acc_x, delta_acc_y,
    // delta_acc_z, delta_rot_vel, delta_rot_acc, time_step, zero pad
    input  logic [((9*WORD_BITS-1+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // move_x, move_y, move_z, turn_amount, zero pad
    output logic [((4*WORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [cemi_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [WORD_BITS-2:0]                   cfg_data
);

    localparam int W        = WORD_BITS;
    localparam int W2       = 2 * WORD_BITS;
    localparam int OUT_BITS = ((4*WORD_BITS+7)/8)*8;
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_LIM   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_NUM   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SPINA = 4'd6;
    localparam logic [3:0] S_TM    = 4'd7;
    localparam logic [3:0] S_SPINR = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1])
            sat_add = s[W] ? NEG_MIN : POS_MAX;
        else
            sat_add = s[W-1:0];
    endfunction

    // clamp a signed value into [-lim, +lim]
    function automatic logic [W-1:0] clamp_sym(input logic [W-1:0] v,
                                               input logic [W-2:0] lim);
        logic [W:0] vs;
        logic [W:0] ls;
        vs = {v[W-1], v};
        ls = {2'b00, lim};
        if ($signed(vs) > $signed(ls))
            clamp_sym = {1'b0, lim};
        else if ($signed(vs) < -$signed(ls))
            clamp_sym = ~{1'b0, lim} + 1'b1;
        else
            clamp_sym = v;
    endfunction

    // motion state
    logic [W-1:0] vel_reg [3];
    logic [W-1:0] acc_reg [3];
    logic [W-1:0] spin_rate_reg;
    logic [W-1:0] spin_acc_reg;

    // limits
    logic [W-2:0] max_accel_reg;
    logic [W-2:0] max_speed_reg;
    logic [W-2:0] max_rot_accel_reg;
    logic [W-2:0] max_rot_speed_reg;

    // sequencer
    logic [3:0]    state_reg;
    logic [1:0]    idx_reg;
    logic          ph_reg;
    logic          vsel_reg;     // 0: acceleration / spin accel, 1: velocity / spin rate
    logic [W-2:0]  ts_reg;
    logic [W2-1:0] prod_reg;
    logic [W2-1:0] sum_reg;
    logic [W-1:0]  root_reg;
    logic [W-1:0]  res_reg [4];
    logic [W-1:0]  out_reg [4];
    logic          out_valid_reg;

    logic [W-1:0]  cur;
    logic [W-1:0]  cur_mag;
    logic [W-2:0]  cap_lim;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic [W2-1:0] tm_sh;
    logic [W-1:0]  tm_mag;
    logic [W-1:0]  tm_val;
    logic [W-1:0]  q_mag;
    logic [W-1:0]  q_val;
    logic          in_acc;
    logic          emit_go;

    cemi_pkg::iter_ctl_t iter_ctl;
    cemi_pkg::iter_sts_t iter_sts;
    logic [W2-1:0]       iter_a;
    logic [W-1:0]        iter_q;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign emit_go       = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    // select the component under work
    always_comb
    begin
        if (idx_reg == 2'd3)
            cur = vsel_reg ? spin_rate_reg : spin_acc_reg;
        else
            cur = vsel_reg ? vel_reg[idx_reg] : acc_reg[idx_reg];
        cur_mag = cur[W-1] ? (~cur + 1'b1) : cur;
        cap_lim = vsel_reg ? max_speed_reg : max_accel_reg;
    end

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_LIM:
            begin
                mul_a = {1'b0, cap_lim};
                mul_b = {1'b0, cap_lim};
            end
            S_NUM, S_DIV:
            begin
                mul_a = cur_mag;
                mul_b = {1'b0, cap_lim};
            end
            S_TM, S_OUT:
            begin
                mul_a = cur_mag;
                mul_b = {1'b0, ts_reg};
            end
            default:
            begin
                mul_a = cur_mag;
                mul_b = cur_mag;
            end
        endcase
    end

    // time product: drop the fraction bits, saturate, restore sign
    always_comb
    begin
        tm_sh = prod_reg >> FRAC_BITS;
        if (cur[W-1])
            tm_mag = (tm_sh > {{W{1'b0}}, NEG_MIN}) ? NEG_MIN : tm_sh[W-1:0];
        else
            tm_mag = (tm_sh > {{W{1'b0}}, POS_MAX}) ? POS_MAX : tm_sh[W-1:0];
        tm_val = cur[W-1] ? (~tm_mag + 1'b1) : tm_mag;
        q_mag  = (iter_q > POS_MAX) ? POS_MAX : iter_q;
        q_val  = cur[W-1] ? (~q_mag + 1'b1) : q_mag;
    end

    assign iter_ctl.start = ((state_reg == S_SQRT) || (state_reg == S_DIV)) && !ph_reg;
    assign iter_ctl.op    = (state_reg == S_SQRT) ? cemi_pkg::OP_SQRT : cemi_pkg::OP_DIV;
    assign iter_a         = (state_reg == S_SQRT) ? sum_reg : prod_reg;

    cemi_iter #(
        .WORD_BITS (WORD_BITS)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (iter_ctl),
        .a      (iter_a),
        .d      (root_reg),
        .sts    (iter_sts),
        .result (iter_q)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= W2'(mul_a) * W2'(mul_b);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg     <= '1;
            max_speed_reg     <= '1;
            max_rot_accel_reg <= '1;
            max_rot_speed_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cemi_pkg::REG_MAX_ACCEL:     max_accel_reg     <= cfg_data;
                cemi_pkg::REG_MAX_SPEED:     max_speed_reg     <= cfg_data;
                cemi_pkg::REG_MAX_ROT_ACCEL: max_rot_accel_reg <= cfg_data;
                cemi_pkg::REG_MAX_ROT_SPEED: max_rot_speed_reg <= cfg_data;
                default:                     max_accel_reg     <= max_accel_reg;
            endcase
        end
    end

    // sequencer and motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            ph_reg        <= 1'b0;
            vsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            spin_rate_reg <= '0;
            spin_acc_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser == cemi_pkg::KIND_ADD)
                        begin
                            // add deltas, no result
                            for (int i = 0; i < 3; i++)
                            begin
                                vel_reg[i] <= sat_add(vel_reg[i], s_axis_tdata[i*W +: W]);
                                acc_reg[i] <= sat_add(acc_reg[i], s_axis_tdata[(i+3)*W +: W]);
                            end
                            spin_rate_reg <= sat_add(spin_rate_reg, s_axis_tdata[6*W +: W]);
                            spin_acc_reg  <= sat_add(spin_acc_reg, s_axis_tdata[7*W +: W]);
                        end
                        else if (s_axis_tdata[8*W +: W-1] != '0)
                        begin
                            idx_reg   <= 2'd0;
                            ph_reg    <= 1'b0;
                            vsel_reg  <= 1'b0;
                            state_reg <= S_SQ;
                        end
                    end
                end

                // accumulate the squared components
                S_SQ:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= 2'd0;
                            state_reg <= S_LIM;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end

                // compare against the squared limit
                S_LIM:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (sum_reg > prod_reg)
                            state_reg <= S_SQRT;
                        else if (!vsel_reg)
                            state_reg <= S_SPINA;
                        else
                            state_reg <= S_SPINR;
                    end
                end

                S_SQRT:
                begin
                    ph_reg <= 1'b1;
                    if (ph_reg && iter_sts.done)
                    begin
                        idx_reg   <= 2'd0;
                        ph_reg    <= 1'b0;
                        state_reg <= S_NUM;
                    end
                end

                S_NUM:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        state_reg <= S_DIV;
                end

                // scale one component by limit / root
                S_DIV:
                begin
                    ph_reg <= 1'b1;
                    if (ph_reg && iter_sts.done)
                    begin
                        ph_reg <= 1'b0;
                        if (vsel_reg)
                            vel_reg[idx_reg] <= q_val;
                        else
                            acc_reg[idx_reg] <= q_val;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg <= 2'd0;
                            if (vsel_reg)
                            begin
                                // speed capped: drop the acceleration
                                for (int i = 0; i < 3; i++)
                                    acc_reg[i] <= '0;
                                state_reg <= S_SPINR;
                            end
                            else
                            begin
                                state_reg <= S_SPINA;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_NUM;
                        end
                    end
                end

                S_SPINA:
                begin
                    spin_acc_reg <= clamp_sym(spin_acc_reg, max_rot_accel_reg);
                    idx_reg      <= 2'd0;
                    ph_reg       <= 1'b0;
                    state_reg    <= S_TM;
                end

                // integrate velocities
                S_TM:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            spin_rate_reg <= sat_add(spin_rate_reg, tm_val);
                            idx_reg       <= 2'd0;
                            vsel_reg      <= 1'b1;
                            state_reg     <= S_SQ;
                        end
                        else
                        begin
                            vel_reg[idx_reg] <= sat_add(vel_reg[idx_reg], tm_val);
                            idx_reg          <= idx_reg + 1'b1;
                        end
                    end
                end

                S_SPINR:
                begin
                    if (clamp_sym(spin_rate_reg, max_rot_speed_reg) != spin_rate_reg)
                    begin
                        spin_rate_reg <= clamp_sym(spin_rate_reg, max_rot_speed_reg);
                        spin_acc_reg  <= '0;
                    end
                    idx_reg   <= 2'd0;
                    ph_reg    <= 1'b0;
                    vsel_reg  <= 1'b1;
                    state_reg <= S_OUT;
                end

                // position and facing deltas
                S_OUT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (idx_reg == 2'd3)
                            state_reg <= S_EMIT;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end

                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ts_reg  <= s_axis_tdata[8*W +: W-1];
            sum_reg <= '0;
        end
        else if (state_reg == S_TM && ph_reg && idx_reg == 2'd3)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == S_SQ && ph_reg)
        begin
            sum_reg <= sum_reg + prod_reg;
        end
        if (state_reg == S_SQRT && ph_reg && iter_sts.done)
            root_reg <= iter_q;
        if (state_reg == S_OUT && ph_reg)
            res_reg[idx_reg] <= tm_val;
        if (emit_go)
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= res_reg[i];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BITS'({out_reg[3], out_reg[2], out_reg[1], out_reg[0]});

`ifndef ASSERT_OFF
    a_iter_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        iter_ctl.start |-> !iter_sts.busy)
        else $error("shared unit started while busy");

    a_zero_step_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser == cemi_pkg::KIND_STEP && s_axis_tdata[8*W +: W-1] == '0)
        |=> state_reg == S_IDLE)
        else $error("zero time step started work");

    a_vec_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ || state_reg == S_NUM || state_reg == S_DIV)
        |-> idx_reg != 2'd3)
        else $error("vector index out of range");

    a_spin_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPINA)
        |=> ($signed({spin_acc_reg[W-1], spin_acc_reg}) <= $signed({2'b00, max_rot_accel_reg})
             && $signed({spin_acc_reg[W-1], spin_acc_reg})
                >= -$signed({2'b00, max_rot_accel_reg})))
        else $error("rotational acceleration not clamped");

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg)
        else $error("pending result dropped");
`endif

endmodule

/* verif/clamped_euler_motion_integrator_test.sv */
`timescale 1ns / 1ps

module clamped_euler_motion_integrator_test;

    localparam int WATCHDOG_LIMIT = 20000;
    // Extra idle time after the last result before the limits change
    localparam int DRAIN_CYCLES = 600;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MIN = -64'sd2147483648;

    typedef struct {
        logic        kind;
        logic [31:0] delta [8];   // vel x/y/z, acc x/y/z, rot vel, rot acc
        logic [30:0] step;
    } motion_word_t;

    typedef struct {
        logic [31:0] move_x;
        logic [31:0] move_y;
        logic [31:0] move_z;
        logic [31:0] turn;
    } move_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic         s_axis_tuser = cemi_pkg::KIND_ADD;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [cemi_pkg::CFG_IDX_BITS-1:0] cfg_index = cemi_pkg::REG_MAX_ACCEL;
    logic [30:0]  cfg_data = '0;

    clamped_euler_motion_integrator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the block's motion state and limits
    longint vel [3];
    longint acc [3];
    longint spin;
    longint spin_acc;
    longint lim_accel, lim_speed, lim_rot_accel, lim_rot_speed;

    motion_word_t pending_words [$];
    move_word_t   expected_moves [$];
    motion_word_t cur_word;
    int  idle_pct = 22;
    int  fail_count = 0;
    int  quiet_cycles = 0;

    function automatic longint sat32(longint s);
        if (s > POS_MAX)
            return POS_MAX;
        if (s < NEG_MIN)
            return NEG_MIN;
        return s;
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // value * step, drop fraction bits, truncate toward zero, saturate
    function automatic longint time_prod(longint v, logic [30:0] t);
        logic [127:0] p;
        logic [63:0]  top;
        p = ({64'b0, mag(v)} * {97'b0, t}) >> 16;
        top = v < 0 ? 64'h8000_0000 : 64'h7fff_ffff;
        if (p > {64'b0, top})
            p = {64'b0, top};
        return v < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'b0, t} * {64'b0, t} <= s)
                r = t;
        end
        return r;
    endfunction

    // Scale the vector down to the limit when its magnitude exceeds it
    function automatic bit cap_vector(bit on_vel, longint lim);
        longint v [3];
        logic [127:0] sum;
        logic [127:0] q;
        logic [63:0]  root;
        for (int i = 0; i < 3; i++)
            v[i] = on_vel ? vel[i] : acc[i];
        sum = '0;
        for (int i = 0; i < 3; i++)
            sum += {64'b0, mag(v[i])} * {64'b0, mag(v[i])};
        if (sum <= {64'b0, mag(lim)} * {64'b0, mag(lim)})
            return 1'b0;
        root = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ({64'b0, mag(v[i])} * {64'b0, mag(lim)}) / {64'b0, root};
            if (q > 128'h7fff_ffff)
                q = 128'h7fff_ffff;
            v[i] = v[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
            if (on_vel)
                vel[i] = v[i];
            else
                acc[i] = v[i];
        end
        return 1'b1;
    endfunction

    function automatic void predict_motion(motion_word_t w);
        move_word_t m;
        if (w.kind == cemi_pkg::KIND_ADD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vel[i] = sat32(vel[i] + longint'($signed(w.delta[i])));
                acc[i] = sat32(acc[i] + longint'($signed(w.delta[3+i])));
            end
            spin     = sat32(spin + longint'($signed(w.delta[6])));
            spin_acc = sat32(spin_acc + longint'($signed(w.delta[7])));
            return;
        end
        if (w.step == '0)
            return;
        void'(cap_vector(1'b0, lim_accel));
        if (spin_acc > lim_rot_accel)
            spin_acc = lim_rot_accel;
        else if (spin_acc < -lim_rot_accel)
            spin_acc = -lim_rot_accel;
        for (int i = 0; i < 3; i++)
            vel[i] = sat32(vel[i] + time_prod(acc[i], w.step));
        spin = sat32(spin + time_prod(spin_acc, w.step));
        if (cap_vector(1'b1, lim_speed))
            for (int i = 0; i < 3; i++)
                acc[i] = 0;
        if (spin > lim_rot_speed)
        begin
            spin = lim_rot_speed;
            spin_acc = 0;
        end
        else if (spin < -lim_rot_speed)
        begin
            spin = -lim_rot_speed;
            spin_acc = 0;
        end
        m.move_x = 32'(time_prod(vel[0], w.step));
        m.move_y = 32'(time_prod(vel[1], w.step));
        m.move_z = 32'(time_prod(vel[2], w.step));
        m.turn   = 32'(time_prod(spin, w.step));
        expected_moves.push_back(m);
    endfunction

    // Driver: hold the word until it is taken, then predict and advance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_motion(cur_word);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_word.kind;
                    s_axis_tdata  <= {1'b0, cur_word.step, cur_word.delta[7],
                                      cur_word.delta[6], cur_word.delta[5],
                                      cur_word.delta[4], cur_word.delta[3],
                                      cur_word.delta[2], cur_word.delta[1],
                                      cur_word.delta[0]};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each taken word with the oldest prediction
    always @(posedge clk)
    begin
        move_word_t exp_m;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_moves.size() == 0)
                begin
                    $error("unexpected result word %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_m = expected_moves.pop_front();
                    if (m_axis_tdata[31:0] !== exp_m.move_x)
                    begin
                        $error("move_x expected %h actual %h", exp_m.move_x,
                               m_axis_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[63:32] !== exp_m.move_y)
                    begin
                        $error("move_y expected %h actual %h", exp_m.move_y,
                               m_axis_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_axis_tdata[95:64] !== exp_m.move_z)
                    begin
                        $error("move_z expected %h actual %h", exp_m.move_z,
                               m_axis_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_axis_tdata[127:96] !== exp_m.turn)
                    begin
                        $error("turn_amount expected %h actual %h", exp_m.turn,
                               m_axis_tdata[127:96]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
        endcase
    endfunction

    function automatic logic [30:0] pick_step();
        case ($urandom_range(19))
            0: return '0;
            1: return 31'h7fff_ffff;
            2, 3: return 31'($urandom);
            default: return 31'($urandom_range(1, 1 << 17));
        endcase
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(5))
            0: return '0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 1 << 22));
        endcase
    endfunction

    function automatic void queue_word(logic kind, logic [31:0] d, logic [30:0] st);
        motion_word_t w;
        w.kind = kind;
        for (int i = 0; i < 8; i++)
            w.delta[i] = d;
        w.step = st;
        pending_words.push_back(w);
    endfunction

    function automatic void queue_random(int n);
        motion_word_t w;
        for (int k = 0; k < n; k++)
        begin
            w.kind = ($urandom_range(99) < 55) ? cemi_pkg::KIND_ADD : cemi_pkg::KIND_STEP;
            for (int i = 0; i < 8; i++)
                w.delta[i] = pick_delta();
            w.step = pick_step();
            pending_words.push_back(w);
        end
    endfunction

    task automatic write_limit(logic [cemi_pkg::CFG_IDX_BITS-1:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            cemi_pkg::REG_MAX_ACCEL:     lim_accel     = longint'(val);
            cemi_pkg::REG_MAX_SPEED:     lim_speed     = longint'(val);
            cemi_pkg::REG_MAX_ROT_ACCEL: lim_rot_accel = longint'(val);
            cemi_pkg::REG_MAX_ROT_SPEED: lim_rot_speed = longint'(val);
            default:                     lim_accel     = lim_accel;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Let the queued words drain, then hold until the block is surely idle
    task automatic drain_to_idle();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_moves.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            vel[i] = 0;
            acc[i] = 0;
        end
        spin = 0;
        spin_acc = 0;
        lim_accel = POS_MAX;
        lim_speed = POS_MAX;
        lim_rot_accel = POS_MAX;
        lim_rot_speed = POS_MAX;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: both kinds, zero and full steps, saturating sums at both ends
        queue_word(cemi_pkg::KIND_STEP, 32'h0, '0);
        queue_word(cemi_pkg::KIND_STEP, 32'h0, 31'h7fff_ffff);
        queue_word(cemi_pkg::KIND_ADD, 32'h7fff_ffff, 31'h7fff_ffff);
        queue_word(cemi_pkg::KIND_ADD, 32'h7fff_ffff, '0);
        queue_word(cemi_pkg::KIND_STEP, 32'h1234_5678, 31'd1);
        queue_word(cemi_pkg::KIND_STEP, 32'h0, 31'h7fff_ffff);
        queue_word(cemi_pkg::KIND_ADD, 32'h8000_0000, '0);
        queue_word(cemi_pkg::KIND_ADD, 32'h8000_0000, '0);
        queue_word(cemi_pkg::KIND_ADD, 32'h8000_0000, '0);
        queue_word(cemi_pkg::KIND_STEP, 32'h0, 31'h0001_0000);
        queue_word(cemi_pkg::KIND_STEP, 32'h0, '0);
        queue_word(cemi_pkg::KIND_ADD, 32'h0001_0000, '0);
        queue_word(cemi_pkg::KIND_STEP, 32'hffff_ffff, 31'h0000_8000);
        drain_to_idle();

        // Zero limits: every nonzero vector collapses, rotations pin to zero
        write_limit(cemi_pkg::REG_MAX_ACCEL, '0);
        write_limit(cemi_pkg::REG_MAX_SPEED, '0);
        write_limit(cemi_pkg::REG_MAX_ROT_ACCEL, '0);
        write_limit(cemi_pkg::REG_MAX_ROT_SPEED, '0);
        queue_word(cemi_pkg::KIND_ADD, 32'h0003_0000, '0);
        queue_word(cemi_pkg::KIND_STEP, 32'h0, 31'h0001_0000);
        queue_word(cemi_pkg::KIND_ADD, 32'hfffd_0000, '0);
        queue_word(cemi_pkg::KIND_STEP, 32'h0, 31'h7fff_ffff);
        drain_to_idle();

        // Random phases, each under a fresh set of limits; one with no idling
        for (int ph = 0; ph < 8; ph++)
        begin
            write_limit(cemi_pkg::REG_MAX_ACCEL, pick_limit());
            write_limit(cemi_pkg::REG_MAX_SPEED, pick_limit());
            write_limit(cemi_pkg::REG_MAX_ROT_ACCEL, pick_limit());
            write_limit(cemi_pkg::REG_MAX_ROT_SPEED, pick_limit());
            idle_pct = (ph == 3) ? 0 : 22;
            queue_random(120);
            drain_to_idle();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
